@@ rtl/core/pngu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared types and constants for the PNG scanline unfilter.
// ----------------------------------------------------------------------------
package pngu_pkg;

    localparam int BYTE_W     = 8;
    localparam int BPP_W      = 4;
    localparam int LINE_W     = 14;
    localparam int ROWS_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int HIST_DEPTH = 8;
    localparam int HIST_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BPP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd2;

    localparam logic [BPP_W-1:0] BPP_MAX = 4'd8;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    // What a word turns into once it reaches the compute stage
    typedef enum logic [1:0] {
        KIND_DROP  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_DATA  = 2'd2,
        KIND_ERR   = 2'd3
    } t_kind;

    function automatic logic [BYTE_W-1:0] paeth_pick(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic signed [BYTE_W+2:0] sa;
        logic signed [BYTE_W+2:0] sb;
        logic signed [BYTE_W+2:0] sc;
        logic signed [BYTE_W+2:0] da;
        logic signed [BYTE_W+2:0] db;
        logic signed [BYTE_W+2:0] dc;
        logic        [BYTE_W+1:0] pa;
        logic        [BYTE_W+1:0] pb;
        logic        [BYTE_W+1:0] pc;
        sa = $signed({3'b000, a});
        sb = $signed({3'b000, b});
        sc = $signed({3'b000, c});
        // p - a = b - c, p - b = a - c, p - c = a + b - 2c
        da = sb - sc;
        db = sa - sc;
        dc = sa + sb - sc - sc;
        pa = (da < 0) ? (BYTE_W+2)'(-da) : (BYTE_W+2)'(da);
        pb = (db < 0) ? (BYTE_W+2)'(-db) : (BYTE_W+2)'(db);
        pc = (dc < 0) ? (BYTE_W+2)'(-dc) : (BYTE_W+2)'(dc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end
        return c;
    endfunction

endpackage

@@ rtl/core/pngu_byte_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngu_byte_if
// Filtered stream channel: one byte per word.
// ----------------------------------------------------------------------------
interface pngu_byte_if;
    import pngu_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

@@ rtl/core/pngu_pix_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngu_pix_if
// Reconstructed byte channel with status and row / image markers.
// ----------------------------------------------------------------------------
interface pngu_pix_if;
    import pngu_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_byte;
    logic              status;
    logic              row_end;
    logic              image_end;

    modport source (output valid, output pixel_byte, output status,
                    output row_end, output image_end, input ready);
    modport sink   (input valid, input pixel_byte, input status,
                    input row_end, input image_end, output ready);
endinterface

@@ rtl/core/png_scanline_unfilter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// Rebuilds raw PNG scanline bytes from the filtered stream (None, Sub, Up,
// Average, Paeth), keeping the previous row in an on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte carries the filtered stream, one byte per word. The first word of
//   each row is the filter type; the next line_bytes words are data. Each
//   data word yields one word on o_pix; the type word yields none. A type
//   above Paeth yields one word with status=1 and the block then drops all
//   input until reset. After the word flagged image_end the block also drops
//   all input until reset.
//   A data word passes the stage 1 register and the output register to o_pix.
//   Throughput: one word per cycle across rows while o_pix.ready is high.
//   Rate set by the prior-row memory: one read at accept, one write in stage 2.
//   Stall: i_byte.ready follows o_pix.ready through one output register, so
//   a new word is still taken while a finished result sits unclaimed as long
//   as the compute stage is empty. Nothing is lost or repeated.
//   Reset (i_rst_n low, synchronous): registers return to bpp=1, line=1,
//   rows=1. The prior-row memory is not swept: a fill mark covers it, and any
//   entry at or beyond the mark reads as zero. Config: i_cfg_we / i_cfg_idx /
//   i_cfg_data; the user must write only while idle, the block does not check.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
    parameter int MAX_LINE_BYTES = 8192
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pngu_byte_if.sink                         i_byte,
    pngu_pix_if.source                        o_pix,
    input  logic                              i_cfg_we,
    input  logic [pngu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pngu_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import pngu_pkg::*;

    localparam int POS_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
    localparam int FILL_W = POS_W + 1;
    // compare width wide enough for both the line register and position + 1
    localparam int CMP_W = ((POS_W > LINE_W) ? POS_W : LINE_W) + 1;
    localparam logic [CMP_W-1:0] LINE_MAX = CMP_W'(MAX_LINE_BYTES);

    typedef struct packed {
        t_kind             kind;
        t_filter           filter;
        logic [POS_W-1:0]  pos;
        logic              b_valid;
        logic              row_end;
        logic              image_end;
        logic [BYTE_W-1:0] x;
    } t_stage;

    // ---------------- configuration registers ----------------
    logic [BPP_W-1:0]  r_bpp;
    logic [LINE_W-1:0] r_line;
    logic [ROWS_W-1:0] r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp  <= BPP_W'(1);
            r_line <= LINE_W'(1);
            r_rows <= ROWS_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BPP:  r_bpp  <= i_cfg_data[BPP_W-1:0];
                CFG_LINE: r_line <= i_cfg_data[LINE_W-1:0];
                CFG_ROWS: r_rows <= i_cfg_data[ROWS_W-1:0];
                default:  ;
            endcase
        end
    end

    // ---------------- control state (stage 1) ----------------
    logic [POS_W-1:0]  r_byte_pos, n_byte_pos;
    logic [ROWS_W-1:0] r_row_idx,  n_row_idx;
    t_filter           r_filter,   n_filter;
    logic              r_await,    n_await;
    logic              r_halted,   n_halted;
    logic [FILL_W-1:0] r_fill,     n_fill;

    t_stage            r_s1, n_s1;
    logic              r_s1_valid, n_s1_valid;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_status;
    logic              r_out_row_end;
    logic              r_out_img_end;

    logic [BYTE_W-1:0] mem [MAX_LINE_BYTES];
    logic [BYTE_W-1:0] r_rd_data;

    logic [BYTE_W-1:0] r_left [HIST_DEPTH];
    logic [BYTE_W-1:0] r_uleft[HIST_DEPTH];

    logic w_adv;     // compute stage may move its word on
    logic w_s1_load; // stage 1 register may take a new word
    logic w_accept;
    logic w_fire;
    logic w_rd_en;
    logic w_wr_en;

    logic [CMP_W-1:0]    w_eff_line;
    logic [CMP_W-1:0]    w_pos_next;
    logic [ROWS_W:0]     w_eff_rows;
    logic [ROWS_W:0]     w_row_next;
    logic                w_row_done;
    logic                w_img_done;

    // stage 2 datapath
    logic [HIST_IDX_W-1:0] w_hidx;
    logic [BYTE_W-1:0]     w_a, w_b, w_c;
    logic [BYTE_W:0]       w_avg_sum;
    logic [BYTE_W-1:0]     w_pred;
    logic [BYTE_W-1:0]     n_out_byte_w;

    assign w_adv     = !r_out_valid || o_pix.ready;
    assign w_s1_load = !r_s1_valid || w_adv;
    assign i_byte.ready = w_s1_load;
    assign w_accept  = i_byte.valid && w_s1_load;
    assign w_fire    = r_s1_valid && w_adv;

    // clamped line length and row count
    always_comb begin
        w_eff_line = CMP_W'(r_line);
        if (w_eff_line == '0) begin
            w_eff_line = CMP_W'(1);
        end else if (w_eff_line > LINE_MAX) begin
            w_eff_line = LINE_MAX;
        end
        w_eff_rows = (r_rows == '0) ? (ROWS_W+1)'(1) : {1'b0, r_rows};
        w_pos_next = CMP_W'(r_byte_pos) + CMP_W'(1);
        w_row_next = {1'b0, r_row_idx} + (ROWS_W+1)'(1);
        w_row_done = (w_pos_next >= w_eff_line);
        w_img_done = w_row_done && (w_row_next >= w_eff_rows);
    end

    // stage 1: classify the word, step position and row counters
    always_comb begin
        n_byte_pos = r_byte_pos;
        n_row_idx  = r_row_idx;
        n_filter   = r_filter;
        n_await    = r_await;
        n_halted   = r_halted;
        w_rd_en    = 1'b0;

        n_s1           = r_s1;
        n_s1.kind      = KIND_DROP;
        n_s1.filter    = r_filter;
        n_s1.pos       = r_byte_pos;
        n_s1.b_valid   = ({1'b0, r_byte_pos} < r_fill);
        n_s1.row_end   = 1'b0;
        n_s1.image_end = 1'b0;
        n_s1.x         = i_byte.data_byte;

        if (w_accept && !r_halted) begin
            if (r_await) begin
                if (i_byte.data_byte > BYTE_W'(FILT_PAETH)) begin
                    n_s1.kind = KIND_ERR;
                    n_halted  = 1'b1;
                end else begin
                    n_s1.kind  = KIND_CLEAR;
                    n_filter   = t_filter'(i_byte.data_byte[2:0]);
                    n_await    = 1'b0;
                    n_byte_pos = '0;
                end
            end else begin
                n_s1.kind      = KIND_DATA;
                n_s1.row_end   = w_row_done;
                n_s1.image_end = w_img_done;
                w_rd_en        = 1'b1;
                if (w_row_done) begin
                    n_byte_pos = '0;
                    n_await    = 1'b1;
                    if (w_img_done) begin
                        n_halted = 1'b1;
                    end else begin
                        n_row_idx = w_row_next[ROWS_W-1:0];
                    end
                end else begin
                    n_byte_pos = w_pos_next[POS_W-1:0];
                end
            end
        end
    end

    assign n_s1_valid = w_s1_load ? w_accept : r_s1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= '0;
            r_row_idx  <= '0;
            r_filter   <= FILT_NONE;
            r_await    <= 1'b1;
            r_halted   <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_byte_pos <= n_byte_pos;
            r_row_idx  <= n_row_idx;
            r_filter   <= n_filter;
            r_await    <= n_await;
            r_halted   <= n_halted;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1 <= n_s1;
        end
    end

    // prior-row memory: read at accept, write back from stage 2
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= mem[r_byte_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_s1.pos] <= n_out_byte_w;
        end
    end

    // ---------------- stage 2: reconstruction ----------------
    always_comb begin
        if (r_bpp == '0) begin
            w_hidx = '0;
        end else if (r_bpp > BPP_MAX) begin
            w_hidx = HIST_IDX_W'(HIST_DEPTH - 1);
        end else begin
            w_hidx = HIST_IDX_W'(r_bpp - BPP_W'(1));
        end
        w_a = r_left[w_hidx];
        w_c = r_uleft[w_hidx];
        // entries never written since reset read as zero
        w_b = r_s1.b_valid ? r_rd_data : '0;
        w_avg_sum = {1'b0, w_a} + {1'b0, w_b};
        case (r_s1.filter)
            FILT_SUB:   w_pred = w_a;
            FILT_UP:    w_pred = w_b;
            FILT_AVG:   w_pred = w_avg_sum[BYTE_W:1];
            FILT_PAETH: w_pred = paeth_pick(w_a, w_b, w_c);
            default:    w_pred = '0;
        endcase
        n_out_byte_w = r_s1.x + w_pred;
    end

    assign w_wr_en = w_fire && (r_s1.kind == KIND_DATA);

    always_comb begin
        n_fill = r_fill;
        if (w_wr_en && ({1'b0, r_s1.pos} + FILL_W'(1) > r_fill)) begin
            n_fill = {1'b0, r_s1.pos} + FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // left and up-left history, newest byte at index 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_left[i]  <= '0;
                r_uleft[i] <= '0;
            end
        end else if (w_fire && r_s1.kind == KIND_CLEAR) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_left[i]  <= '0;
                r_uleft[i] <= '0;
            end
        end else if (w_wr_en) begin
            r_left[0]  <= n_out_byte_w;
            r_uleft[0] <= w_b;
            for (int i = 1; i < HIST_DEPTH; i++) begin
                r_left[i]  <= r_left[i-1];
                r_uleft[i] <= r_uleft[i-1];
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid &&
                           (r_s1.kind == KIND_DATA || r_s1.kind == KIND_ERR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_s1.kind == KIND_ERR) begin
                r_out_byte    <= '0;
                r_out_status  <= 1'b1;
                r_out_row_end <= 1'b0;
                r_out_img_end <= 1'b0;
            end else begin
                r_out_byte    <= n_out_byte_w;
                r_out_status  <= 1'b0;
                r_out_row_end <= r_s1.row_end;
                r_out_img_end <= r_s1.image_end;
            end
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_byte = r_out_byte;
    assign o_pix.status     = r_out_status;
    assign o_pix.row_end    = r_out_row_end;
    assign o_pix.image_end  = r_out_img_end;

    // ---------------- assertions ----------------
    // a read never lands on the entry being written in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rd_en && w_wr_en) |-> (r_byte_pos != r_s1.pos))
        else $error("prior-row read and write hit the same entry");

    // fill mark never passes the memory depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(MAX_LINE_BYTES))
        else $error("fill mark beyond memory depth");

    // with both stages empty the input is always open
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s1_valid && !r_out_valid) |-> i_byte.ready)
        else $error("input blocked while pipeline is empty");

    // an image end word halts the block from the following cycle
    a_halt_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_s1.kind == KIND_DATA && r_s1.image_end) |-> r_halted)
        else $error("image end reached without halting");

endmodule
